[hw/rtl/urc_pkg.sv]
`default_nettype none

package urc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_BURST_PULSES = 2'd0;
  localparam logic [1:0] CFG_PERIOD_TICKS = 2'd1;
  localparam logic [1:0] CFG_HIGH_TICKS   = 2'd2;
  localparam logic [1:0] CFG_OFFSET_CM    = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  RST_BURST_PULSES = 8'd20;
  localparam logic [15:0] RST_PERIOD_TICKS = 16'd625;
  localparam logic [15:0] RST_HIGH_TICKS   = 16'd312;
  localparam logic [7:0]  RST_OFFSET_CM    = 8'd2;

  // Flight ticks are carried zero-extended to the widest counter
  localparam int TOF_W = 32;
  // Flight counts of 2^TOF_LOW_W ticks or more saturate the distance in any case
  localparam int TOF_LOW_W = 25;
  // ticks * 34400 / 50000000 reduces to ticks * 43 / 62500
  localparam int PROD_W = 31;
  localparam logic [PROD_W-1:0] SCALE_NUM = PROD_W'(43);
  localparam logic [31:0] SCALE_DEN = 32'd62500;
  // Reciprocal of the denominator, scaled by 2^46 and rounded down
  localparam int RECIP_SHIFT = 46;
  localparam logic [PROD_W-1:0] RECIP = PROD_W'(1125899906);
  localparam int QUOT_W = 16;

  localparam int DIST_W = 14;
  localparam logic [DIST_W-1:0] DIST_MAX = 14'd16383;

  typedef enum logic [1:0] {
    DIST_HOLD,
    DIST_CLEAR,
    DIST_LOAD
  } dist_op_t;

  // Per-tick result fields that ride alongside the distance arithmetic
  typedef struct packed {
    logic     burst_level;
    logic     busy;
    dist_op_t op;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/urc_tof_calc.sv]
`default_nettype none

module urc_tof_calc
  import urc_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire side_t        in_side,
  input  wire  [TOF_W-1:0]  in_ticks,
  output logic              out_valid,
  input  wire               out_ready,
  output side_t             out_side,
  output logic              out_sat,
  output logic [QUOT_W-1:0] out_quot
);

  logic                a_v_r, b_v_r, c_v_r;
  logic                a_rdy, b_rdy, c_rdy;
  side_t               a_side_r, b_side_r, c_side_r;
  logic                a_sat_r, b_sat_r, c_sat_r;
  logic [PROD_W-1:0]   a_prod_r, b_prod_r;
  logic [QUOT_W-1:0]   b_quot_r, c_quot_r;
  logic [2*PROD_W-1:0] recip_prod;
  logic [31:0]         remainder;
  logic [QUOT_W-1:0]   quot_fix;

  // Each stage moves on when it is empty or its successor takes its request
  assign c_rdy    = !c_v_r || out_ready;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  // Reciprocal multiply gives the quotient or one less
  assign recip_prod = (2*PROD_W)'(a_prod_r) * (2*PROD_W)'(RECIP);

  // Remainder check corrects the estimate by one
  assign remainder = 32'(b_prod_r) - 32'(b_quot_r) * SCALE_DEN;
  assign quot_fix  = (remainder >= SCALE_DEN) ? b_quot_r + QUOT_W'(1) : b_quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
    end
  end

  // Scale ticks and flag counts that saturate the distance
  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_side_r <= in_side;
      a_sat_r  <= |in_ticks[TOF_W-1:TOF_LOW_W];
      a_prod_r <= PROD_W'(in_ticks[TOF_LOW_W-1:0]) * SCALE_NUM;
    end
  end

  // Estimate quotient
  always_ff @(posedge clk) begin
    if (b_rdy && a_v_r) begin
      b_side_r <= a_side_r;
      b_sat_r  <= a_sat_r;
      b_prod_r <= a_prod_r;
      b_quot_r <= recip_prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // Correct quotient
  always_ff @(posedge clk) begin
    if (c_rdy && b_v_r) begin
      c_side_r <= b_side_r;
      c_sat_r  <= b_sat_r;
      c_quot_r <= quot_fix;
    end
  end

  assign out_valid = c_v_r;
  assign out_side  = c_side_r;
  assign out_sat   = c_sat_r;
  assign out_quot  = c_quot_r;

endmodule

`default_nettype wire

[hw/rtl/ultrasonic_range_controller.sv]
// A request is registered in s1, the three u_calc stages and the result register in turn.
// Throughput: one request per cycle unless out_tready stalls the output; a three-stage
//   reciprocal multiply and remainder correction turns captured flight ticks into centimetres.
// Reset (synchronous, rst_n low): burst, timer, echo history and stored
//   distance clear, registers return to their defaults and the pipeline empties.
`default_nettype none

module ultrasonic_range_controller
  import urc_pkg::*;
#(
  parameter int COUNTER_BITS = 24
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // bit 0 start_req, bit 1 echo_level, rest zero
  input  wire  [7:0]           in_tdata,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  // bit 0 burst_level, bit 1 busy_res, bits 15:2 distance_cm
  output logic [15:0]          out_tdata,
  // bit 0 done_res
  output logic                 out_tuser,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready
);

  localparam logic [COUNTER_BITS-1:0] TICKS_MAX = '1;

  // Configuration registers
  logic [7:0]  burst_pulses_r;
  logic [15:0] period_ticks_r, high_ticks_r;
  logic [7:0]  offset_cm_r;

  // Tick state
  logic [7:0]              pulses_left_r, pulses_left_nxt;
  logic [15:0]             phase_count_r, phase_count_nxt;
  logic                    burst_on_r, burst_on_nxt;
  logic [COUNTER_BITS-1:0] flight_r, flight_nxt;
  logic                    timing_on_r, timing_on_nxt;
  logic                    echo_prev_r;

  // Front stage and result register
  logic               s1_v_r;
  side_t              s1_side_r, side_nxt;
  logic [TOF_W-1:0]   s1_ticks_r, ticks_nxt;
  logic               out_v_r;
  side_t              out_side_r;
  logic [DIST_W-1:0]  dist_r;

  logic               in_fire, rise, busy_before, go, level;
  logic [7:0]         pulses_cur;
  logic [15:0]        phase_cur;
  logic               burst_cur;
  logic [COUNTER_BITS-1:0] flight_cur;
  logic               calc_in_ready, calc_valid, calc_sat, out_rdy;
  side_t              calc_side;
  logic [QUOT_W-1:0]  calc_quot;
  logic [QUOT_W:0]    dist_sum;
  logic [DIST_W-1:0]  dist_new;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !s1_v_r || calc_in_ready;

  // Start, echo edge and burst stepping for one tick
  always_comb begin
    rise        = in_tdata[1] && !echo_prev_r;
    busy_before = burst_on_r || timing_on_r || (flight_r != '0);
    go          = in_tdata[0] && !busy_before;

    pulses_cur  = go ? ((burst_pulses_r == 8'd0) ? 8'd1 : burst_pulses_r) : pulses_left_r;
    phase_cur   = go ? 16'd0 : phase_count_r;
    burst_cur   = go || burst_on_r;
    flight_cur  = go ? '0 : flight_r;

    // Timer: stop on echo edge, else count and hold at full scale
    ticks_nxt     = '0;
    timing_on_nxt = go || timing_on_r;
    flight_nxt    = flight_cur;
    if (rise) begin
      ticks_nxt     = TOF_W'(flight_cur);
      timing_on_nxt = 1'b0;
      flight_nxt    = '0;
    end else if (timing_on_nxt && flight_cur != TICKS_MAX) begin
      flight_nxt = flight_cur + COUNTER_BITS'(1);
    end

    // Burst: high for the first part of each period
    level           = 1'b0;
    pulses_left_nxt = pulses_cur;
    phase_count_nxt = phase_cur;
    burst_on_nxt    = burst_cur;
    if (burst_cur) begin
      level = phase_cur < high_ticks_r;
      if ({1'b0, phase_cur} + 17'd1 >= {1'b0, period_ticks_r}) begin
        phase_count_nxt = 16'd0;
        pulses_left_nxt = pulses_cur - 8'd1;
        if (pulses_cur == 8'd1) burst_on_nxt = 1'b0;
      end else begin
        phase_count_nxt = phase_cur + 16'd1;
      end
    end

    side_nxt.burst_level = level;
    side_nxt.busy        = burst_on_nxt || timing_on_nxt || (flight_nxt != '0);
    priority if (rise) side_nxt.op = DIST_LOAD;
    else if (go)       side_nxt.op = DIST_CLEAR;
    else               side_nxt.op = DIST_HOLD;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_pulses_r <= RST_BURST_PULSES;
      period_ticks_r <= RST_PERIOD_TICKS;
      high_ticks_r   <= RST_HIGH_TICKS;
      offset_cm_r    <= RST_OFFSET_CM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BURST_PULSES: burst_pulses_r <= cfg_data[7:0];
        CFG_PERIOD_TICKS: period_ticks_r <= cfg_data;
        CFG_HIGH_TICKS:   high_ticks_r   <= cfg_data;
        CFG_OFFSET_CM:    offset_cm_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Advance tick state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulses_left_r <= 8'd0;
      phase_count_r <= 16'd0;
      burst_on_r    <= 1'b0;
      flight_r      <= '0;
      timing_on_r   <= 1'b0;
      echo_prev_r   <= 1'b0;
      s1_v_r        <= 1'b0;
    end else begin
      if (in_fire) begin
        pulses_left_r <= pulses_left_nxt;
        phase_count_r <= phase_count_nxt;
        burst_on_r    <= burst_on_nxt;
        flight_r      <= flight_nxt;
        timing_on_r   <= timing_on_nxt;
        echo_prev_r   <= in_tdata[1];
      end
      if (in_tready) s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_side_r  <= side_nxt;
      s1_ticks_r <= ticks_nxt;
    end
  end

  urc_tof_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (calc_in_ready),
    .in_side   (s1_side_r),
    .in_ticks  (s1_ticks_r),
    .out_valid (calc_valid),
    .out_ready (out_rdy),
    .out_side  (calc_side),
    .out_sat   (calc_sat),
    .out_quot  (calc_quot)
  );

  // Add offset and clamp
  assign dist_sum = (QUOT_W + 1)'(calc_quot) + (QUOT_W + 1)'(offset_cm_r);
  assign dist_new = (calc_sat || dist_sum > (QUOT_W + 1)'(DIST_MAX)) ? DIST_MAX
                                                                      : dist_sum[DIST_W-1:0];
  assign out_rdy  = !out_v_r || out_tready;

  // Result register; dist_r also holds the stored distance between echoes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      dist_r  <= '0;
    end else if (out_rdy) begin
      out_v_r <= calc_valid;
      if (calc_valid) begin
        unique case (calc_side.op)
          DIST_LOAD:  dist_r <= dist_new;
          DIST_CLEAR: dist_r <= '0;
          DIST_HOLD:  dist_r <= dist_r;
          default:    dist_r <= dist_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && calc_valid) out_side_r <= calc_side;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {dist_r, out_side_r.busy, out_side_r.burst_level};
  assign out_tuser  = (out_side_r.op == DIST_LOAD);

endmodule

`default_nettype wire
